// ===== sv/fdc_pkg.sv =====
// Package with types, codes and constants of the floppy controller engine.
`default_nettype none
package fdc_pkg;
   localparam int unsigned SectorBytesDefault = 512;
   localparam int unsigned MaxParams = 8;
   localparam int unsigned ResultBytes = 7;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_CMD  = 2'd1,
      PH_EXEC = 2'd2,
      PH_RES  = 2'd3
   } phase_type;

   localparam logic [2:0] KIND_DOR_WR  = 3'd0;
   localparam logic [2:0] KIND_MSR_RD  = 3'd1;
   localparam logic [2:0] KIND_FIFO_WR = 3'd2;
   localparam logic [2:0] KIND_FIFO_RD = 3'd3;
   localparam logic [2:0] KIND_CCR_WR  = 3'd4;

   localparam logic [7:0] OP_SPECIFY = 8'h03;
   localparam logic [7:0] OP_RECAL   = 8'h07;
   localparam logic [7:0] OP_SEEK    = 8'h0F;
   localparam logic [7:0] OP_SENSE   = 8'h08;
   localparam logic [4:0] OP_READ5   = 5'h06;
   localparam logic [4:0] OP_WRITE5  = 5'h05;

   localparam logic [7:0] ST0_INVALID = 8'h80;
   localparam logic [7:0] ST0_RESET   = 8'hC0;
   localparam logic [7:0] ST0_SEEKEND = 8'h20;

   localparam logic [7:0] MSR_IDLE  = 8'h80;
   localparam logic [7:0] MSR_CMD   = 8'h90;
   localparam logic [7:0] MSR_RES   = 8'hD0;
   localparam logic [7:0] MSR_EXRD  = 8'hF0;
   localparam logic [7:0] MSR_EXWR  = 8'hB0;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] write_data;
      logic [7:0] media_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_line;
      logic       media_write_valid;
      logic [7:0] media_write_byte;
      logic       media_read_valid;
      logic [7:0] target_cylinder;
      logic       target_head;
      logic [7:0] target_sector;
      logic [8:0] byte_offset;
      logic       motor_running;
   } rsp_type;

   function automatic logic is_read_op(input logic [7:0] op);
      return op[4:0] == OP_READ5;
   endfunction

   function automatic logic is_write_op(input logic [7:0] op);
      return op[4:0] == OP_WRITE5;
   endfunction
endpackage
`default_nettype wire

// ===== sv/fdc_if.sv =====
// Valid/ready channel interface carrying one beat of a payload type.
`default_nettype none
interface fdc_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/floppy_controller_fifo_engine_core.sv =====
// Top level of the floppy controller engine: host access decode, phases and result register.
//
// Each request beat is one host register access (DOR, MSR, FIFO or CCR). The access is
// decoded and its effect on the command, execution and result phases computed
// combinationally between the request input and a single output register; one beat is
// taken per cycle while the request side is ready, and it stays ready while the output
// register is empty or being drained in the same cycle. SECTOR_BYTES sets the transfer
// length before a sector is closed as if terminal count had been given.
`default_nettype none
module floppy_controller_fifo_engine_core
   import fdc_pkg::*;
#(
   parameter int unsigned SECTOR_BYTES = SectorBytesDefault
) (
   input wire logic clock,
   input wire logic reset,
   fdc_if.sink      req,
   fdc_if.source    rsp
);
   localparam int unsigned CntW = $clog2(SECTOR_BYTES + 1);

   // Architectural state.
   phase_type    phase_ff, phase_in;
   logic [7:0]   opcode_ff, opcode_in;
   logic [3:0]   pcount_ff, pcount_in;
   logic [7:0]   params_ff [MaxParams];
   logic [7:0]   results_ff [ResultBytes];
   logic [7:0]   results_in [ResultBytes];
   logic         res_we;
   logic [2:0]   ridx_ff, ridx_in, rlen_ff, rlen_in;
   logic [CntW-1:0] xfer_ff, xfer_in;
   logic [7:0]   pcn_ff, pcn_in;
   logic         intr_ff, intr_in;
   logic [2:0]   sense_ff, sense_in;
   logic [7:0]   seekst_ff, seekst_in;
   logic [7:0]   dor_ff, dor_in;
   logic [15:0]  spec_ff, spec_in;
   logic [1:0]   rate_ff, rate_in;
   logic         pwe;
   logic [2:0]   pwa;

   // Output register.
   logic         ovalid_ff;
   rsp_type      odata_ff, odata_in;
   logic         take;

   assign req.ready = !ovalid_ff || rsp.ready;
   assign take      = req.valid && req.ready;
   assign rsp.valid   = ovalid_ff;
   assign rsp.payload = odata_ff;

   // Next state and result computation for one access.
   always_comb begin
      logic       live;
      logic [7:0] op;
      logic [7:0] wd;
      logic       moved;
      logic       run;
      logic [3:0] need;
      logic       known;
      logic [7:0] p [MaxParams];
      logic [7:0] c, r;
      logic       h;
      logic [1:0] drv;
      logic [2:0] sdec;
      logic [CntW-1:0] xnext;

      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      pcount_in = pcount_ff;
      results_in = results_ff;
      res_we    = 1'b0;
      ridx_in   = ridx_ff;
      rlen_in   = rlen_ff;
      xfer_in   = xfer_ff;
      pcn_in    = pcn_ff;
      intr_in   = intr_ff;
      sense_in  = sense_ff;
      seekst_in = seekst_ff;
      dor_in    = dor_ff;
      spec_in   = spec_ff;
      rate_in   = rate_ff;
      pwe       = 1'b0;
      pwa       = pcount_ff[2:0];
      odata_in  = '0;
      moved     = 1'b0;
      run       = 1'b0;
      need      = 4'd0;
      known     = 1'b1;
      c = 8'd0; r = 8'd0; h = 1'b0; drv = 2'd0; sdec = 3'd0; xnext = '0;
      live      = dor_ff[2];
      wd        = req.payload.write_data;
      op        = opcode_ff;
      p         = params_ff;

      case (req.payload.kind)
         KIND_DOR_WR: begin
            dor_in = wd;
            if (!wd[2]) begin
               phase_in = PH_IDLE; opcode_in = '0; pcount_in = '0; ridx_in = '0;
               rlen_in = '0; xfer_in = '0; intr_in = 1'b0; sense_in = '0;
            end else if (!live) begin
               intr_in = 1'b1; sense_in = 3'd4; seekst_in = ST0_RESET;
            end
         end
         KIND_MSR_RD: begin
            if (!live) odata_in.read_data = '0;
            else begin
               case (phase_ff)
                  PH_CMD:  odata_in.read_data = MSR_CMD;
                  PH_RES:  odata_in.read_data = MSR_RES;
                  PH_EXEC: odata_in.read_data = is_read_op(opcode_ff) ? MSR_EXRD : MSR_EXWR;
                  default: odata_in.read_data = MSR_IDLE;
               endcase
            end
         end
         KIND_CCR_WR: rate_in = wd[1:0];
         KIND_FIFO_WR: begin
            if (live) begin
               if (phase_ff == PH_IDLE) begin
                  op = wd; opcode_in = wd; pcount_in = '0;
                  if (wd == OP_SENSE) run = 1'b1;
                  else if (wd == OP_SPECIFY || wd == OP_RECAL || wd == OP_SEEK ||
                           is_read_op(wd) || is_write_op(wd)) phase_in = PH_CMD;
                  else known = 1'b0;
               end else if (phase_ff == PH_CMD) begin
                  pwe = 1'b1;
                  p[pcount_ff[2:0]] = wd;
                  pcount_in = pcount_ff + 4'd1;
                  if (op == OP_SPECIFY || op == OP_SEEK) need = 4'd2;
                  else if (op == OP_RECAL) need = 4'd1;
                  else need = 4'd8;
                  if (pcount_in >= need) run = 1'b1;
               end else if (phase_ff == PH_EXEC && is_write_op(opcode_ff)) begin
                  odata_in.media_write_valid = 1'b1;
                  odata_in.media_write_byte  = wd;
                  moved = 1'b1;
               end
            end
         end
         KIND_FIFO_RD: begin
            if (live) begin
               if (phase_ff == PH_RES) begin
                  if (ridx_ff == 3'd0 && (is_read_op(opcode_ff) || is_write_op(opcode_ff)))
                     intr_in = 1'b0;
                  odata_in.read_data = (ridx_ff < 3'(ResultBytes)) ? results_ff[ridx_ff] :
                                       results_ff[0];
                  ridx_in = ridx_ff + 3'd1;
                  if (ridx_in >= rlen_ff) begin
                     ridx_in = '0; rlen_in = '0; phase_in = PH_IDLE;
                  end
               end else if (phase_ff == PH_EXEC && is_read_op(opcode_ff)) begin
                  odata_in.read_data = req.payload.media_byte;
                  odata_in.media_read_valid = 1'b1;
                  moved = 1'b1;
               end
            end
         end
         default: ;
      endcase

      // Unknown opcode: single invalid status byte.
      if (!known) begin
         res_we = 1'b1; results_in[0] = ST0_INVALID;
         ridx_in = '0; rlen_in = 3'd1; phase_in = PH_RES;
      end

      // Command execution once all parameters are in.
      if (run) begin
         if (op == OP_SPECIFY) begin
            spec_in = {p[0], p[1]}; phase_in = PH_IDLE;
         end else if (op == OP_RECAL || op == OP_SEEK) begin
            pcn_in = (op == OP_RECAL) ? 8'd0 : p[1];
            seekst_in = ST0_SEEKEND | (p[0] & ((op == OP_RECAL) ? 8'h03 : 8'h07));
            intr_in = 1'b1; sense_in = '0; phase_in = PH_IDLE;
         end else if (op == OP_SENSE) begin
            res_we = 1'b1; ridx_in = '0; phase_in = PH_RES;
            if (sense_ff != 3'd0) begin
               sdec = 3'd4 - sense_ff;
               drv = sdec[1:0];
               results_in[0] = ST0_RESET | {6'd0, drv};
               results_in[1] = (drv == 2'd0) ? pcn_ff : 8'd0;
               sense_in = sense_ff - 3'd1;
               if (sense_in == 3'd0) intr_in = 1'b0;
               rlen_in = 3'd2;
            end else if (intr_ff) begin
               results_in[0] = seekst_ff; results_in[1] = pcn_ff;
               intr_in = 1'b0; rlen_in = 3'd2;
            end else begin
               results_in[0] = ST0_INVALID; rlen_in = 3'd1;
            end
         end else begin
            xfer_in = '0; phase_in = PH_EXEC;
         end
      end

      // Sector byte moved: position report and end of sector.
      if (moved) begin
         odata_in.target_cylinder = params_ff[1];
         odata_in.target_head     = params_ff[2][0];
         odata_in.target_sector   = params_ff[3];
         odata_in.byte_offset     = 9'(xfer_ff);
         xnext = xfer_ff + 1'b1;
         xfer_in = xnext;
         if (xnext >= CntW'(SECTOR_BYTES)) begin
            xfer_in = '0;
            c = params_ff[1]; h = params_ff[2][0]; r = params_ff[3];
            if (r == params_ff[5]) begin
               r = 8'd1;
               if (opcode_ff[7] && !h) h = 1'b1;
               else begin h = 1'b0; c = c + 8'd1; end
            end else r = r + 8'd1;
            res_we = 1'b1;
            results_in[0] = params_ff[0] & 8'h07;
            results_in[1] = 8'd0; results_in[2] = 8'd0;
            results_in[3] = c; results_in[4] = {7'd0, h};
            results_in[5] = r; results_in[6] = params_ff[4];
            ridx_in = '0; rlen_in = 3'(ResultBytes);
            intr_in = 1'b1; phase_in = PH_RES;
         end
      end

      odata_in.irq_line      = intr_in && dor_in[3];
      odata_in.motor_running = dor_in[4];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; opcode_ff <= '0; pcount_ff <= '0; ridx_ff <= '0;
         rlen_ff <= '0; xfer_ff <= '0; pcn_ff <= '0; intr_ff <= 1'b0; sense_ff <= '0;
         seekst_ff <= '0; dor_ff <= '0; spec_ff <= '0; rate_ff <= '0; ovalid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in; opcode_ff <= opcode_in; pcount_ff <= pcount_in;
            ridx_ff <= ridx_in; rlen_ff <= rlen_in; xfer_ff <= xfer_in; pcn_ff <= pcn_in;
            intr_ff <= intr_in; sense_ff <= sense_in; seekst_ff <= seekst_in;
            dor_ff <= dor_in; spec_ff <= spec_in; rate_ff <= rate_in;
         end
         if (take) ovalid_ff <= 1'b1;
         else if (rsp.ready) ovalid_ff <= 1'b0;
      end
   end

   // Payload registers and stores.
   always_ff @(posedge clock) begin
      if (take) begin
         odata_ff <= odata_in;
         if (pwe) params_ff[pwa] <= req.payload.write_data;
         if (res_we) results_ff <= results_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/fdc_checker.sv =====
// Port-level checker for the floppy controller engine, bound to the top level.
`default_nettype none
module fdc_checker
   import fdc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_payload,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);
   // An accepted access always yields a beat on the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted access gave no result beat");

   // A stalled result beat holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

   // Media read and media write never flag together.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.media_read_valid && rsp_payload.media_write_valid))
      else $error("media read and write in one beat");

   // A DOR write reflects motor bit four in its result.
   a_motor: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.kind == KIND_DOR_WR
      |=> rsp_payload.motor_running == $past(req_payload.write_data[4]))
      else $error("motor bit not taken from DOR write");
endmodule

bind floppy_controller_fifo_engine_core fdc_checker u_fdc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .req_payload(req.payload),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_payload(rsp.payload)
);
`default_nettype wire
